// ===== rtl/tgsa_pkg.sv =====
// ----------------------------------------------------------------------------
// tgsa_pkg
// Shared types and constants of the ticket-gated slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package tgsa_pkg;

  localparam int SLOT_MAX_DEF = 16;

  localparam int KIND_W   = 2;
  localparam int TICKET_W = 64;
  localparam int OFFSET_W = 32;
  localparam int STATUS_W = 3;
  localparam int SCOUNT_W = 5;
  localparam int BSIZE_W  = 28;
  localparam int CFG_IDX_W = 1;

  localparam logic [SCOUNT_W-1:0] SCOUNT_RST = SCOUNT_W'(16);
  localparam logic [BSIZE_W-1:0]  BSIZE_RST  = BSIZE_W'(4096);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUNDLE_SIZE = 1'b1;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_DRAW    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACQUIRE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NOP     = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK             = 3'd0;
  localparam logic [STATUS_W-1:0] ST_GATE_CLOSED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SLOT        = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_OFFSET     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DOUBLE_RELEASE = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [TICKET_W-1:0] ticket;
    logic [OFFSET_W-1:0] bundle_offset;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TICKET_W-1:0] ticket_out;
    logic [OFFSET_W-1:0] slot_offset;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/ticket_gated_slot_allocator_core.sv =====
// sequence: draw, no-op and release with zero bundle size go straight to S_FIN;
//   acquire runs S_GATE (to S_FIN when closed), then S_SCAN from slot 0 upward;
//   release runs S_DIV (one quotient bit per cycle over the 32-bit offset) and S_RCHK
// throughput: one transaction at a time, set by the shared add/subtract unit
//   that runs the gate compare, the slot scan and the restoring divider
// reset: synchronous active-low; counters zero, all slots free, slot_count 16,
//   bundle_size 4096, no result pending
// ----------------------------------------------------------------------------
// ticket_gated_slot_allocator_core
// Fixed slot pool handed out under a ticket gate, with an iterative sequencer
// around one shared 64-bit add/subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none

module ticket_gated_slot_allocator_core #(
  parameter int SLOT_MAX = tgsa_pkg::SLOT_MAX_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire tgsa_pkg::in_t                       in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output tgsa_pkg::out_t                           out_data,
  input  wire logic                                cfg_we,
  input  wire logic [tgsa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tgsa_pkg::BSIZE_W-1:0]        cfg_wdata
);

  localparam int CW  = $clog2(SLOT_MAX + 1);
  localparam int NW  = (CW > tgsa_pkg::SCOUNT_W) ? CW : tgsa_pkg::SCOUNT_W;
  localparam int SIW = (SLOT_MAX > 1) ? $clog2(SLOT_MAX) : 1;
  localparam int TW  = tgsa_pkg::TICKET_W;
  localparam int OW  = tgsa_pkg::OFFSET_W;
  localparam int BW  = tgsa_pkg::BSIZE_W;
  localparam int DCW = $clog2(OW);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_GATE = 6'b000010,
    S_SCAN = 6'b000100,
    S_DIV  = 6'b001000,
    S_RCHK = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [tgsa_pkg::SCOUNT_W-1:0]   slot_count_r, slot_count_nxt;
  logic [BW-1:0]                   bundle_r, bundle_nxt;
  logic [TW-1:0]                   draw_cnt_r, draw_cnt_nxt;
  logic [TW-1:0]                   release_cnt_r, release_cnt_nxt;
  logic [SLOT_MAX-1:0]             busy_r, busy_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [NW-1:0]                   idx_r, idx_nxt;
  logic [DCW-1:0]                  div_cnt_r, div_cnt_nxt;

  logic [TW-1:0]                   ticket_r, ticket_nxt;
  logic [OW-1:0]                   acc_r, acc_nxt;
  logic [OW-1:0]                   quo_r, quo_nxt;
  logic [BW-1:0]                   rem_r, rem_nxt;
  tgsa_pkg::out_t                  res_r, res_nxt;
  tgsa_pkg::out_t                  out_r, out_nxt;

  logic [NW-1:0]                   n_act;
  logic [TW-1:0]                   alu_a, alu_b;
  logic                            alu_sub;
  logic [TW:0]                     alu_sum;
  logic [BW:0]                     trial;
  logic                            in_fire;

  // active slot count, saturated to the pool size
  assign n_act = (NW'(slot_count_r) > NW'(SLOT_MAX)) ? NW'(SLOT_MAX) : NW'(slot_count_r);

  assign trial   = {rem_r, quo_r[OW-1]};
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // shared add/subtract unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      S_GATE: begin
        alu_a   = ticket_r;
        alu_b   = release_cnt_r;
        alu_sub = 1'b1;
      end
      S_SCAN: begin
        alu_a = TW'(acc_r);
        alu_b = TW'(bundle_r);
      end
      S_DIV: begin
        alu_a   = TW'(trial);
        alu_b   = TW'(bundle_r);
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
    alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (TW + 1)'(alu_sub);
  end

  always_comb begin
    state_nxt       = state_r;
    slot_count_nxt  = slot_count_r;
    bundle_nxt      = bundle_r;
    draw_cnt_nxt    = draw_cnt_r;
    release_cnt_nxt = release_cnt_r;
    busy_nxt        = busy_r;
    out_valid_nxt   = out_valid_r;
    idx_nxt         = idx_r;
    div_cnt_nxt     = div_cnt_r;
    ticket_nxt      = ticket_r;
    acc_nxt         = acc_r;
    quo_nxt         = quo_r;
    rem_nxt         = rem_r;
    res_nxt         = res_r;
    out_nxt         = out_r;

    if (cfg_we) begin
      case (cfg_index)
        tgsa_pkg::CFG_SLOT_COUNT:  slot_count_nxt = cfg_wdata[tgsa_pkg::SCOUNT_W-1:0];
        tgsa_pkg::CFG_BUNDLE_SIZE: bundle_nxt = cfg_wdata;
        default:                   bundle_nxt = bundle_r;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_nxt     = '0;
          ticket_nxt  = in_data.ticket;
          idx_nxt     = '0;
          acc_nxt     = '0;
          rem_nxt     = '0;
          quo_nxt     = in_data.bundle_offset;
          div_cnt_nxt = '0;
          case (in_data.kind)
            tgsa_pkg::KIND_DRAW: begin
              res_nxt.ticket_out = draw_cnt_r;
              draw_cnt_nxt       = draw_cnt_r + TW'(1);
              state_nxt          = S_FIN;
            end
            tgsa_pkg::KIND_ACQUIRE: begin
              state_nxt = S_GATE;
            end
            tgsa_pkg::KIND_RELEASE: begin
              if (bundle_r == '0) begin
                res_nxt.status = tgsa_pkg::ST_BAD_OFFSET;
                state_nxt      = S_FIN;
              end else begin
                state_nxt = S_DIV;
              end
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_GATE: begin
        // distance of the ticket past the release count, modulo 2^64
        if (alu_sum[TW-1:0] >= TW'(n_act)) begin
          res_nxt.status = tgsa_pkg::ST_GATE_CLOSED;
          state_nxt      = S_FIN;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx_r >= n_act) begin
          res_nxt.status = tgsa_pkg::ST_NO_SLOT;
          state_nxt      = S_FIN;
        end else if (!busy_r[idx_r[SIW-1:0]]) begin
          busy_nxt[idx_r[SIW-1:0]] = 1'b1;
          res_nxt.slot_offset      = acc_r;
          state_nxt                = S_FIN;
        end else begin
          idx_nxt = idx_r + NW'(1);
          acc_nxt = alu_sum[OW-1:0];
        end
      end
      S_DIV: begin
        // restoring division, one quotient bit per cycle
        if (alu_sum[TW]) begin
          rem_nxt = alu_sum[BW-1:0];
          quo_nxt = {quo_r[OW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[BW-1:0];
          quo_nxt = {quo_r[OW-2:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r + DCW'(1);
        if (div_cnt_r == DCW'(OW - 1)) begin
          state_nxt = S_RCHK;
        end
      end
      S_RCHK: begin
        if ((rem_r != '0) || (quo_r >= OW'(n_act))) begin
          res_nxt.status = tgsa_pkg::ST_BAD_OFFSET;
        end else if (!busy_r[quo_r[SIW-1:0]]) begin
          res_nxt.status = tgsa_pkg::ST_DOUBLE_RELEASE;
        end else begin
          busy_nxt[quo_r[SIW-1:0]] = 1'b0;
          release_cnt_nxt          = release_cnt_r + TW'(1);
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      slot_count_r  <= tgsa_pkg::SCOUNT_RST;
      bundle_r      <= tgsa_pkg::BSIZE_RST;
      draw_cnt_r    <= '0;
      release_cnt_r <= '0;
      busy_r        <= '0;
      out_valid_r   <= 1'b0;
      idx_r         <= '0;
      div_cnt_r     <= '0;
    end else begin
      state_r       <= state_nxt;
      slot_count_r  <= slot_count_nxt;
      bundle_r      <= bundle_nxt;
      draw_cnt_r    <= draw_cnt_nxt;
      release_cnt_r <= release_cnt_nxt;
      busy_r        <= busy_nxt;
      out_valid_r   <= out_valid_nxt;
      idx_r         <= idx_nxt;
      div_cnt_r     <= div_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ticket_r <= ticket_nxt;
    acc_r    <= acc_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/tgsa_checker.sv =====
// ----------------------------------------------------------------------------
// tgsa_checker
// Port-level checks of the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tgsa_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire tgsa_pkg::out_t out_data
);

  // a pending result is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // one transaction in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new transaction taken while busy");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == tgsa_pkg::ST_OK) ||
                  (out_data.status == tgsa_pkg::ST_GATE_CLOSED) ||
                  (out_data.status == tgsa_pkg::ST_NO_SLOT) ||
                  (out_data.status == tgsa_pkg::ST_BAD_OFFSET) ||
                  (out_data.status == tgsa_pkg::ST_DOUBLE_RELEASE))
    else $error("undefined status code");

  // failed requests carry no ticket and no offset
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != tgsa_pkg::ST_OK) |->
      (out_data.ticket_out == '0) && (out_data.slot_offset == '0))
    else $error("error result with nonzero payload");

endmodule

bind ticket_gated_slot_allocator_core tgsa_checker u_tgsa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the ticket-gated slot allocator: draws, gated acquires and offset
// releases are driven through valid/ready with random stalls on both sides,
// and each result is compared against a cycle-free model of the slot pool.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int PHASE_ITEMS = 103;

  // model of the pool; holds predicted results in acceptance order
  class slot_pool_scoreboard;
    logic [tgsa_pkg::SCOUNT_W-1:0] slot_count;
    logic [tgsa_pkg::BSIZE_W-1:0]  bundle_size;
    logic [63:0]                   draw_cnt;
    logic [63:0]                   release_cnt;
    bit                            busy [tgsa_pkg::SLOT_MAX_DEF];
    tgsa_pkg::out_t                pending_results [$];
    int                            errors;
    int                            requests;
    int                            results;
    int                            status_seen [8];

    function new();
      slot_count  = tgsa_pkg::SCOUNT_RST;
      bundle_size = tgsa_pkg::BSIZE_RST;
      draw_cnt    = '0;
      release_cnt = '0;
      foreach (busy[i]) busy[i] = 1'b0;
      foreach (status_seen[i]) status_seen[i] = 0;
      errors   = 0;
      requests = 0;
      results  = 0;
    endfunction

    function void set_reg(logic [tgsa_pkg::CFG_IDX_W-1:0] idx,
                          logic [tgsa_pkg::BSIZE_W-1:0] data);
      if (idx == tgsa_pkg::CFG_SLOT_COUNT) begin
        slot_count = data[tgsa_pkg::SCOUNT_W-1:0];
      end else begin
        bundle_size = data;
      end
    endfunction

    function int active_slots();
      return (slot_count > tgsa_pkg::SLOT_MAX_DEF) ? tgsa_pkg::SLOT_MAX_DEF
                                                   : int'(slot_count);
    endfunction

    function void note_request(tgsa_pkg::in_t req);
      tgsa_pkg::out_t res;
      logic [63:0]    n64;
      logic [63:0]    span;
      logic [63:0]    prod;
      logic [63:0]    off;
      logic [63:0]    bs;
      logic [63:0]    idx;
      bit             found;
      n64   = 64'(active_slots());
      bs    = 64'(bundle_size);
      off   = 64'(req.bundle_offset);
      res   = '0;
      found = 1'b0;
      res.status = tgsa_pkg::ST_OK;
      if (req.kind == tgsa_pkg::KIND_DRAW) begin
        res.ticket_out = draw_cnt;
        draw_cnt       = draw_cnt + 64'd1;
      end else if (req.kind == tgsa_pkg::KIND_ACQUIRE) begin
        span = req.ticket - release_cnt;
        if (span >= n64) begin
          res.status = tgsa_pkg::ST_GATE_CLOSED;
        end else begin
          res.status = tgsa_pkg::ST_NO_SLOT;
          for (int i = 0; i < tgsa_pkg::SLOT_MAX_DEF; i++) begin
            if (!found && 64'(i) < n64 && !busy[i]) begin
              found      = 1'b1;
              busy[i]    = 1'b1;
              prod       = 64'(i) * bs;
              res.slot_offset = prod[31:0];
              res.status = tgsa_pkg::ST_OK;
            end
          end
        end
      end else if (req.kind == tgsa_pkg::KIND_RELEASE) begin
        if (bs == 0 || (off % bs) != 0 || (off / bs) >= n64) begin
          res.status = tgsa_pkg::ST_BAD_OFFSET;
        end else begin
          idx = off / bs;
          if (!busy[idx]) begin
            res.status = tgsa_pkg::ST_DOUBLE_RELEASE;
          end else begin
            busy[idx]   = 1'b0;
            release_cnt = release_cnt + 64'd1;
          end
        end
      end
      pending_results.push_back(res);
      requests++;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(tgsa_pkg::out_t got);
      tgsa_pkg::out_t want;
      results++;
      status_seen[got.status]++;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing outstanding (code %0d)", got.status));
        return;
      end
      want = pending_results.pop_front();
      if (got.status != want.status)
        report($sformatf("result %0d code got %0d want %0d", results, got.status,
                         want.status));
      if (got.ticket_out != want.ticket_out)
        report($sformatf("result %0d ticket_out got %0h want %0h", results,
                         got.ticket_out, want.ticket_out));
      if (got.slot_offset != want.slot_offset)
        report($sformatf("result %0d slot_offset got %0h want %0h", results,
                         got.slot_offset, want.slot_offset));
    endtask
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  tgsa_pkg::in_t                  in_data;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  tgsa_pkg::out_t                 out_data;
  logic                           cfg_we;
  logic [tgsa_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tgsa_pkg::BSIZE_W-1:0]   cfg_wdata;

  slot_pool_scoreboard sb = new();
  int                  tx_idle_pct = 0;
  int                  rx_idle_pct = 0;
  int                  cycles = 0;
  int                  settings = 0;

  ticket_gated_slot_allocator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               sb.pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // transaction monitor on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task send(tgsa_pkg::in_t item);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task drain();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task write_reg(logic [tgsa_pkg::CFG_IDX_W-1:0] idx, logic [tgsa_pkg::BSIZE_W-1:0] data);
    cfg_index <= idx;
    cfg_wdata <= data;
    cfg_we    <= 1'b1;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task apply_setting(logic [tgsa_pkg::BSIZE_W-1:0] slots,
                     logic [tgsa_pkg::BSIZE_W-1:0] bsize);
    drain();
    write_reg(tgsa_pkg::CFG_SLOT_COUNT, slots);
    write_reg(tgsa_pkg::CFG_BUNDLE_SIZE, bsize);
    settings++;
  endtask

  function automatic tgsa_pkg::in_t request(logic [tgsa_pkg::KIND_W-1:0] kind,
                                            logic [63:0] ticket, logic [31:0] offset);
    tgsa_pkg::in_t it;
    it.kind          = kind;
    it.ticket        = ticket;
    it.bundle_offset = offset;
    return it;
  endfunction

  // draws, mostly gate-passing acquires and mostly aligned releases of in-range slots
  function automatic tgsa_pkg::in_t random_request();
    tgsa_pkg::in_t it;
    int            n;
    int            pick;
    int            k;
    logic [63:0]   prod;
    it.kind          = tgsa_pkg::KIND_W'($urandom_range(3));
    it.ticket        = {$urandom, $urandom};
    it.bundle_offset = $urandom;
    n    = sb.active_slots();
    pick = $urandom_range(99);
    if (pick < 8) return it;
    if (pick < 35) begin
      it.kind = tgsa_pkg::KIND_DRAW;
    end else if (pick < 68) begin
      it.kind = tgsa_pkg::KIND_ACQUIRE;
      k = $urandom_range(19);
      if (k == 0) begin
        it.ticket = sb.release_cnt - 64'd1;
      end else if (k == 1) begin
        it.ticket = sb.release_cnt + 64'(n);
      end else if (k > 2) begin
        it.ticket = sb.release_cnt + 64'($urandom_range(n > 0 ? n - 1 : 0));
      end
    end else begin
      it.kind = tgsa_pkg::KIND_RELEASE;
      k = $urandom_range(19);
      prod = 64'($urandom_range(n > 0 ? n - 1 : 0)) * 64'(sb.bundle_size);
      if (k == 0) prod = 64'(n) * 64'(sb.bundle_size);
      if (k == 1) prod = prod + 64'd1;
      if (k != 2) it.bundle_offset = prod[31:0];
    end
    return it;
  endfunction

  initial begin
    logic [tgsa_pkg::BSIZE_W-1:0] slot_set [5];
    logic [tgsa_pkg::BSIZE_W-1:0] size_set [5];
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = tgsa_pkg::CFG_SLOT_COUNT;
    cfg_wdata = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset setting of 16 slots of 4096 bytes
    send(request(tgsa_pkg::KIND_DRAW, '1, '1));
    send(request(tgsa_pkg::KIND_DRAW, '0, '0));
    send(request(tgsa_pkg::KIND_ACQUIRE, 64'd0, '1));
    send(request(tgsa_pkg::KIND_ACQUIRE, 64'd0, '0));     // same ticket again
    send(request(tgsa_pkg::KIND_ACQUIRE, '1, '0));        // wraps below release count
    send(request(tgsa_pkg::KIND_ACQUIRE, 64'd16, '0));
    send(request(tgsa_pkg::KIND_ACQUIRE, 64'd15, '0));
    send(request(tgsa_pkg::KIND_RELEASE, '0, 32'd4096));
    send(request(tgsa_pkg::KIND_RELEASE, '0, 32'd4096));  // already free
    send(request(tgsa_pkg::KIND_RELEASE, '0, 32'd4097));
    send(request(tgsa_pkg::KIND_RELEASE, '0, 32'd65536));
    send(request(tgsa_pkg::KIND_RELEASE, '0, '1));
    send(request(tgsa_pkg::KIND_ACQUIRE, 64'd16, '0));
    send(request(tgsa_pkg::KIND_NOP, '1, '1));
    send(request(tgsa_pkg::KIND_NOP, '0, '0));
    // single slot already taken: gate open but nothing free
    apply_setting(1, tgsa_pkg::BSIZE_RST);
    send(request(tgsa_pkg::KIND_ACQUIRE, 64'd1, '0));
    send(request(tgsa_pkg::KIND_RELEASE, '0, 32'd0));
    send(request(tgsa_pkg::KIND_ACQUIRE, 64'd2, '0));
    apply_setting(0, tgsa_pkg::BSIZE_RST);
    send(request(tgsa_pkg::KIND_ACQUIRE, 64'd2, '0));
    send(request(tgsa_pkg::KIND_RELEASE, '0, 32'd0));
    // count above the pool saturates, zero size gives zero offsets
    apply_setting(31, 0);
    send(request(tgsa_pkg::KIND_ACQUIRE, 64'd2, '0));
    send(request(tgsa_pkg::KIND_RELEASE, '0, 32'd0));
    apply_setting(16, 28'hFFF_FFFF);
    send(request(tgsa_pkg::KIND_RELEASE, '0, 32'h2FFF_FFFD));
    send(request(tgsa_pkg::KIND_ACQUIRE, 64'd2, '0));
    send(request(tgsa_pkg::KIND_DRAW, '0, '0));

    slot_set = '{16, 1, 31, 5, 11};
    size_set = '{tgsa_pkg::BSIZE_RST, 1, 28'hFFF_FFFF, 3,
                 tgsa_pkg::BSIZE_W'($urandom_range(1 << 20, 1))};
    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 21 : (mode == 1) ? 66 : 0;
      rx_idle_pct = (mode == 0) ? 66 : (mode == 1) ? 21 : 0;
      for (int s = 0; s < 5; s++) begin
        apply_setting(slot_set[s], size_set[s]);
        for (int i = 0; i < PHASE_ITEMS; i++) begin
          if (mode == 0 && s == 0 && i == PHASE_ITEMS / 2) drain();
          send(random_request());
        end
      end
    end

    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (40) @(posedge clk);

    $display("ran %0d requests over %0d register settings, %0d results checked",
             sb.requests, settings, sb.results);
    $display("ok %0d, gate closed %0d, no slot %0d, bad offset %0d, double release %0d",
             sb.status_seen[tgsa_pkg::ST_OK], sb.status_seen[tgsa_pkg::ST_GATE_CLOSED],
             sb.status_seen[tgsa_pkg::ST_NO_SLOT], sb.status_seen[tgsa_pkg::ST_BAD_OFFSET],
             sb.status_seen[tgsa_pkg::ST_DOUBLE_RELEASE]);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
